// ===== rtl/uds_transfer_data_server_assert.svh =====
// assertion macros used by the transfer data server top level
`ifndef UDS_TRANSFER_DATA_SERVER_ASSERT_SVH
`define UDS_TRANSFER_DATA_SERVER_ASSERT_SVH

// same-cycle implication
`define UDS_TD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uds_td same-cycle check failed");

// next-cycle implication
`define UDS_TD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uds_td next-cycle check failed");

`endif

// ===== rtl/uds_td_pkg.sv =====
// types, codes and constants of the transfer data server
package uds_td_pkg;

    localparam int unsigned BUFFER_BYTES = 4096;
    localparam int unsigned LEN_W        = 16;
    localparam logic [31:0] UP_CAP       = 32'(BUFFER_BYTES - 2);
    localparam logic [12:0] NEG_LEN      = 13'd3;
    localparam logic [12:0] ACK_LEN      = 13'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DW    = 3'd1,
        PH_DWTD  = 3'd2,
        PH_DWFIN = 3'd3,
        PH_UP    = 3'd4,
        PH_UPTD  = 3'd5,
        PH_UPFIN = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_XFER  = 2'd1,
        FN_POLL  = 2'd2,
        FN_EXIT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DIR_DOWNLOAD = 2'd0,
        DIR_UPLOAD   = 2'd1
    } dir_t;

    typedef enum logic [1:0] {
        FS_SUCCESS   = 2'd0,
        FS_PROG_FAIL = 2'd1,
        FS_BAD_ADDR  = 2'd2,
        FS_BUSY      = 2'd3
    } flash_status_t;

    typedef enum logic [1:0] {
        KIND_POS  = 2'd0,
        KIND_NEG  = 2'd1,
        KIND_WAIT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        NRC_NONE      = 3'd0,
        NRC_BAD_LEN   = 3'd1,
        NRC_SEQUENCE  = 3'd2,
        NRC_PROG_FAIL = 3'd3,
        NRC_SUSPENDED = 3'd4,
        NRC_WRONG_CNT = 3'd5,
        NRC_PENDING   = 3'd6
    } nrc_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] request_length;
        logic [7:0]  block_counter;
        logic [1:0]  direction;
        logic [31:0] address;
        logic [31:0] transfer_size;
        logic [1:0]  flash_status;
        logic        flash_ready;
    } req_t;

    typedef struct packed {
        logic [1:0]  response_kind;
        logic [2:0]  nrc;
        logic [12:0] response_length;
        logic [7:0]  counter_echo;
        logic        write_start;
        logic        read_start;
        logic [31:0] read_address;
        logic [12:0] data_length;
        logic        enter_exit_state;
        logic        accepted;
        logic        fully_idle;
    } rsp_t;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       download_counter;
        logic [7:0]       upload_counter;
        logic [31:0]      remaining_size;
        logic [31:0]      next_address;
        logic [LEN_W-1:0] previous_length;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:            PH_IDLE,
        download_counter: 8'd0,
        upload_counter:   8'd0,
        remaining_size:   32'd0,
        next_address:     32'd0,
        previous_length:  '0
    };

endpackage

// ===== rtl/uds_td_if.sv =====
// request and response channel interfaces of the transfer data server

interface uds_td_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [12:0] request_length;
    logic [7:0]  block_counter;
    logic [1:0]  direction;
    logic [31:0] address;
    logic [31:0] transfer_size;
    logic [1:0]  flash_status;
    logic        flash_ready;

    modport source (
        output valid, func, request_length, block_counter, direction,
               address, transfer_size, flash_status, flash_ready,
        input  ready
    );
    modport sink (
        input  valid, func, request_length, block_counter, direction,
               address, transfer_size, flash_status, flash_ready,
        output ready
    );
endinterface

interface uds_td_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  response_kind;
    logic [2:0]  nrc;
    logic [12:0] response_length;
    logic [7:0]  counter_echo;
    logic        write_start;
    logic        read_start;
    logic [31:0] read_address;
    logic [12:0] data_length;
    logic        enter_exit_state;
    logic        accepted;
    logic        fully_idle;

    modport source (
        output valid, response_kind, nrc, response_length, counter_echo,
               write_start, read_start, read_address, data_length,
               enter_exit_state, accepted, fully_idle,
        input  ready
    );
    modport sink (
        input  valid, response_kind, nrc, response_length, counter_echo,
               write_start, read_start, read_address, data_length,
               enter_exit_state, accepted, fully_idle,
        output ready
    );
endinterface

// ===== rtl/uds_td_core.sv =====
// request decision logic: next transfer state and response of one transaction
module uds_td_core (
    input  uds_td_pkg::state_t cur_state,
    input  uds_td_pkg::req_t   req,
    output uds_td_pkg::state_t nxt_state,
    output uds_td_pkg::rsp_t   rsp
);
    import uds_td_pkg::*;

    logic [12:0]      dlen;
    logic [7:0]       dc_prev;
    logic [7:0]       uc_prev;
    logic [LEN_W-1:0] ulen;
    logic [LEN_W-1:0] ulen_rsp;
    logic [LEN_W-1:0] prev_rsp;
    logic             in_download;
    logic             in_upload;
    logic             busy;

    always_comb
    begin
        nxt_state = cur_state;
        rsp       = '0;

        dlen     = req.request_length - 13'd2;
        dc_prev  = cur_state.download_counter - 8'd1;
        uc_prev  = cur_state.upload_counter - 8'd1;
        ulen     = (cur_state.remaining_size > UP_CAP) ? UP_CAP[LEN_W-1:0]
                                                       : cur_state.remaining_size[LEN_W-1:0];
        ulen_rsp = ulen + LEN_W'(2);
        prev_rsp = cur_state.previous_length + LEN_W'(2);

        in_download = (cur_state.phase == PH_DW) || (cur_state.phase == PH_DWTD) ||
                      (cur_state.phase == PH_DWFIN);
        in_upload   = (cur_state.phase == PH_UP) || (cur_state.phase == PH_UPTD) ||
                      (cur_state.phase == PH_UPFIN);
        busy        = (cur_state.phase == PH_DWTD) || (cur_state.phase == PH_DWFIN) ||
                      (cur_state.phase == PH_UPTD) || (cur_state.phase == PH_UPFIN);

        case (req.func)
            FN_START:
            begin
                if (!busy)
                begin
                    case (req.direction)
                        DIR_DOWNLOAD:
                        begin
                            nxt_state.phase            = PH_DW;
                            nxt_state.download_counter = 8'd1;
                            nxt_state.upload_counter   = 8'd0;
                        end
                        DIR_UPLOAD:
                        begin
                            nxt_state.phase            = PH_UP;
                            nxt_state.upload_counter   = 8'd1;
                            nxt_state.download_counter = 8'd0;
                        end
                        default:
                        begin
                            nxt_state.phase = PH_IDLE;
                        end
                    endcase
                    nxt_state.next_address    = req.address;
                    nxt_state.remaining_size  = req.transfer_size;
                    nxt_state.previous_length = '0;
                    rsp.accepted              = 1'b1;
                end
            end
            FN_EXIT:
            begin
                nxt_state = STATE_RESET;
            end
            default:
            begin
                if (req.request_length <= 13'd1)
                begin
                    rsp.response_kind   = KIND_NEG;
                    rsp.nrc             = NRC_BAD_LEN;
                    rsp.response_length = NEG_LEN;
                end
                else if (in_download && (req.func == FN_POLL))
                begin
                    case (req.flash_status)
                        FS_SUCCESS:
                        begin
                            nxt_state.download_counter = cur_state.download_counter + 8'd1;
                            if (cur_state.remaining_size == 32'd0)
                            begin
                                nxt_state.phase      = PH_DWFIN;
                                rsp.enter_exit_state = 1'b1;
                            end
                            else if (cur_state.remaining_size < {19'd0, dlen})
                            begin
                                nxt_state.remaining_size = {19'd0, dlen};
                            end
                            rsp.response_kind   = KIND_POS;
                            rsp.response_length = ACK_LEN;
                            rsp.counter_echo    = cur_state.download_counter;
                        end
                        FS_PROG_FAIL, FS_BAD_ADDR:
                        begin
                            nxt_state           = STATE_RESET;
                            rsp.response_kind   = KIND_NEG;
                            rsp.nrc             = NRC_PROG_FAIL;
                            rsp.response_length = NEG_LEN;
                        end
                        default:
                        begin
                            rsp.response_kind = KIND_WAIT;
                            rsp.nrc           = NRC_PENDING;
                        end
                    endcase
                end
                else if (in_download)
                begin
                    if ((cur_state.phase != PH_DWFIN) &&
                        (cur_state.download_counter == req.block_counter))
                    begin
                        if ({19'd0, dlen} <= cur_state.remaining_size)
                        begin
                            if (req.flash_ready)
                            begin
                                rsp.counter_echo    = cur_state.download_counter;
                                rsp.write_start     = 1'b1;
                                rsp.data_length     = dlen;
                                nxt_state.phase     = PH_DWTD;
                                rsp.response_kind   = KIND_NEG;
                                rsp.nrc             = NRC_PENDING;
                                rsp.response_length = NEG_LEN;
                            end
                            else
                            begin
                                nxt_state           = STATE_RESET;
                                rsp.response_kind   = KIND_NEG;
                                rsp.nrc             = NRC_PROG_FAIL;
                                rsp.response_length = NEG_LEN;
                            end
                        end
                        else
                        begin
                            rsp.response_kind   = KIND_NEG;
                            rsp.nrc             = NRC_SUSPENDED;
                            rsp.response_length = NEG_LEN;
                        end
                    end
                    else if ((cur_state.phase != PH_DW) && (dc_prev == req.block_counter))
                    begin
                        rsp.response_kind   = KIND_POS;
                        rsp.response_length = ACK_LEN;
                        rsp.counter_echo    = dc_prev;
                    end
                    else if (cur_state.phase == PH_DWFIN)
                    begin
                        rsp.response_kind   = KIND_NEG;
                        rsp.nrc             = NRC_SEQUENCE;
                        rsp.response_length = NEG_LEN;
                    end
                    else
                    begin
                        rsp.response_kind   = KIND_NEG;
                        rsp.nrc             = NRC_WRONG_CNT;
                        rsp.response_length = NEG_LEN;
                    end
                end
                else if (in_upload)
                begin
                    if ((cur_state.phase != PH_UPFIN) &&
                        (cur_state.upload_counter == req.block_counter))
                    begin
                        rsp.read_start              = 1'b1;
                        rsp.read_address            = cur_state.next_address;
                        rsp.data_length             = ulen[12:0];
                        rsp.response_kind           = KIND_POS;
                        rsp.response_length         = ulen_rsp[12:0];
                        rsp.counter_echo            = cur_state.upload_counter;
                        nxt_state.remaining_size    = cur_state.remaining_size -
                                                      32'(ulen);
                        nxt_state.next_address      = cur_state.next_address + 32'(ulen);
                        nxt_state.previous_length   = ulen;
                        nxt_state.upload_counter    = cur_state.upload_counter + 8'd1;
                        nxt_state.phase = (cur_state.remaining_size == 32'(ulen)) ? PH_UPFIN
                                                                                   : PH_UPTD;
                    end
                    else if ((cur_state.phase != PH_UP) && (uc_prev == req.block_counter))
                    begin
                        rsp.response_kind   = KIND_POS;
                        rsp.response_length = prev_rsp[12:0];
                        rsp.counter_echo    = uc_prev;
                    end
                    else if (cur_state.phase == PH_UPFIN)
                    begin
                        rsp.response_kind   = KIND_NEG;
                        rsp.nrc             = NRC_SEQUENCE;
                        rsp.response_length = NEG_LEN;
                    end
                    else
                    begin
                        rsp.response_kind   = KIND_NEG;
                        rsp.nrc             = NRC_WRONG_CNT;
                        rsp.response_length = NEG_LEN;
                    end
                end
                else
                begin
                    nxt_state.phase     = PH_IDLE;
                    rsp.response_kind   = KIND_NEG;
                    rsp.nrc             = NRC_SEQUENCE;
                    rsp.response_length = NEG_LEN;
                end
            end
        endcase

        rsp.fully_idle = (nxt_state.phase == PH_IDLE) &&
                         (nxt_state.download_counter == 8'd0) &&
                         (nxt_state.upload_counter == 8'd0);
    end

endmodule

// ===== rtl/uds_transfer_data_server.sv =====
// top level of the transfer data server
// One response per request transaction. A request is held in an input register,
// decided combinationally against the transfer state and written to the response
// register, and a new request can be taken every cycle while the response is not
// stalled. The decision logic between the two registers is combinational; a stalled
// response backs up into the input register and then drops req.ready.
`include "uds_transfer_data_server_assert.svh"

module uds_transfer_data_server (
    input  logic          clk,
    input  logic          rst_n,
    uds_td_req_if.sink    req,
    uds_td_rsp_if.source  rsp
);
    import uds_td_pkg::*;

    req_t   req_reg;
    logic   req_valid_reg;
    logic   req_valid_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    state_t state_reg;
    state_t state_next;
    rsp_t   rsp_next;
    req_t   req_in;
    logic   advance;
    logic   take;

    uds_td_core u_core (
        .cur_state (state_reg),
        .req       (req_reg),
        .nxt_state (state_next),
        .rsp       (rsp_next)
    );

    assign req_in = '{
        func:           req.func,
        request_length: req.request_length,
        block_counter:  req.block_counter,
        direction:      req.direction,
        address:        req.address,
        transfer_size:  req.transfer_size,
        flash_status:   req.flash_status,
        flash_ready:    req.flash_ready
    };

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign req_valid_next = take || (req_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_in;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.response_kind    = rsp_reg.response_kind;
    assign rsp.nrc              = rsp_reg.nrc;
    assign rsp.response_length  = rsp_reg.response_length;
    assign rsp.counter_echo     = rsp_reg.counter_echo;
    assign rsp.write_start      = rsp_reg.write_start;
    assign rsp.read_start       = rsp_reg.read_start;
    assign rsp.read_address     = rsp_reg.read_address;
    assign rsp.data_length      = rsp_reg.data_length;
    assign rsp.enter_exit_state = rsp_reg.enter_exit_state;
    assign rsp.accepted         = rsp_reg.accepted;
    assign rsp.fully_idle       = rsp_reg.fully_idle;

    // full input stage behind a stalled response takes nothing
    `UDS_TD_ASSERT_IMPLY(a_stall_backs_up, clk, rst_n,
        req_valid_reg && rsp_valid_reg && !rsp.ready, !req.ready)

    // a flash write leaves the download waiting for the flash writer
    `UDS_TD_ASSERT_NEXT(a_write_waits, clk, rst_n,
        advance && rsp_next.write_start, state_reg.phase == PH_DWTD)

    // an upload read never exceeds the response buffer
    `UDS_TD_ASSERT_IMPLY(a_read_fits, clk, rst_n,
        advance && rsp_next.read_start, {19'd0, rsp_next.data_length} <= UP_CAP)

    // a read and a write never come from the same transaction
    `UDS_TD_ASSERT_IMPLY(a_one_command, clk, rst_n,
        rsp_valid_reg, !(rsp_reg.read_start && rsp_reg.write_start))

endmodule

// ===== tb/uds_transfer_data_server_checker.sv =====
// transfer data server checker: predicts each response and compares it with the block
`timescale 1ns / 1ps

module uds_transfer_data_server_checker (
    input  logic  clk,
    input  logic  rst_n,
    uds_td_req_if req,
    uds_td_rsp_if rsp,
    output int    failures,
    output int    outstanding
);
    import uds_td_pkg::*;

    phase_t           ph;
    logic [7:0]       dl_cnt;
    logic [7:0]       ul_cnt;
    logic [31:0]      rem_size;
    logic [31:0]      nxt_addr;
    logic [LEN_W-1:0] prev_len;
    rsp_t             resp;
    rsp_t             expected_responses[$];
    req_t             incoming;
    rsp_t             observed;
    rsp_t             wanted;

    function void clear_state();
        ph       = PH_IDLE;
        dl_cnt   = 8'd0;
        ul_cnt   = 8'd0;
        rem_size = 32'd0;
        nxt_addr = 32'd0;
        prev_len = '0;
    endfunction

    function void reject(nrc_t code);
        resp.response_kind   = KIND_NEG;
        resp.nrc             = code;
        resp.response_length = NEG_LEN;
    endfunction

    function void ack(logic [12:0] len, logic [7:0] echo);
        resp.response_kind   = KIND_POS;
        resp.response_length = len;
        resp.counter_echo    = echo;
    endfunction

    function automatic rsp_t serve_request(req_t r);
        logic [15:0] len;
        logic [15:0] up_len;
        logic [7:0]  echo;
        resp = '0;
        len  = 16'(r.request_length) - 16'd2;
        case (r.func)
            FN_START:
            begin
                if (ph inside {PH_DWTD, PH_DWFIN, PH_UPTD, PH_UPFIN})
                begin
                    resp.accepted = 1'b0;
                end
                else
                begin
                    if (r.direction == DIR_DOWNLOAD)
                    begin
                        ph     = PH_DW;
                        dl_cnt = 8'd1;
                        ul_cnt = 8'd0;
                    end
                    else if (r.direction == DIR_UPLOAD)
                    begin
                        ph     = PH_UP;
                        ul_cnt = 8'd1;
                        dl_cnt = 8'd0;
                    end
                    else
                    begin
                        ph = PH_IDLE;
                    end
                    nxt_addr      = r.address;
                    rem_size      = r.transfer_size;
                    prev_len      = '0;
                    resp.accepted = 1'b1;
                end
            end
            FN_EXIT:
            begin
                clear_state();
            end
            default:
            begin
                if (r.request_length <= 13'd1)
                begin
                    reject(NRC_BAD_LEN);
                end
                else if (ph inside {PH_DW, PH_DWTD, PH_DWFIN})
                begin
                    if (r.func == FN_POLL)
                    begin
                        if (r.flash_status == FS_SUCCESS)
                        begin
                            echo   = dl_cnt;
                            dl_cnt = dl_cnt + 8'd1;
                            if (rem_size == 32'd0)
                            begin
                                ph                    = PH_DWFIN;
                                resp.enter_exit_state = 1'b1;
                            end
                            else if (rem_size < 32'(len))
                            begin
                                rem_size = 32'(len);
                            end
                            ack(ACK_LEN, echo);
                        end
                        else if (r.flash_status == FS_PROG_FAIL ||
                                 r.flash_status == FS_BAD_ADDR)
                        begin
                            clear_state();
                            reject(NRC_PROG_FAIL);
                        end
                        else
                        begin
                            resp.response_kind = KIND_WAIT;
                            resp.nrc           = NRC_PENDING;
                        end
                    end
                    else if (ph != PH_DWFIN && dl_cnt == r.block_counter)
                    begin
                        if (32'(len) <= rem_size)
                        begin
                            if (r.flash_ready)
                            begin
                                resp.counter_echo = dl_cnt;
                                resp.write_start  = 1'b1;
                                resp.data_length  = len[12:0];
                                ph                = PH_DWTD;
                                reject(NRC_PENDING);
                            end
                            else
                            begin
                                clear_state();
                                reject(NRC_PROG_FAIL);
                            end
                        end
                        else
                        begin
                            reject(NRC_SUSPENDED);
                        end
                    end
                    else if (ph != PH_DW && 8'(dl_cnt - 8'd1) == r.block_counter)
                    begin
                        ack(ACK_LEN, 8'(dl_cnt - 8'd1));
                    end
                    else if (ph == PH_DWFIN)
                    begin
                        reject(NRC_SEQUENCE);
                    end
                    else
                    begin
                        reject(NRC_WRONG_CNT);
                    end
                end
                else if (ph inside {PH_UP, PH_UPTD, PH_UPFIN})
                begin
                    if (ph != PH_UPFIN && ul_cnt == r.block_counter)
                    begin
                        up_len            = (rem_size > UP_CAP) ? UP_CAP[15:0] : rem_size[15:0];
                        resp.read_start   = 1'b1;
                        resp.read_address = nxt_addr;
                        resp.data_length  = up_len[12:0];
                        rem_size          = rem_size - 32'(up_len);
                        nxt_addr          = nxt_addr + 32'(up_len);
                        prev_len          = up_len;
                        ack(13'(up_len + 16'd2), ul_cnt);
                        ul_cnt = ul_cnt + 8'd1;
                        if (rem_size == 32'd0)
                        begin
                            ph = PH_UPFIN;
                        end
                        else
                        begin
                            ph = PH_UPTD;
                        end
                    end
                    else if (ph != PH_UP && 8'(ul_cnt - 8'd1) == r.block_counter)
                    begin
                        ack(13'(prev_len + 16'd2), 8'(ul_cnt - 8'd1));
                    end
                    else if (ph == PH_UPFIN)
                    begin
                        reject(NRC_SEQUENCE);
                    end
                    else
                    begin
                        reject(NRC_WRONG_CNT);
                    end
                end
                else
                begin
                    ph = PH_IDLE;
                    reject(NRC_SEQUENCE);
                end
            end
        endcase
        resp.fully_idle = (ph == PH_IDLE && dl_cnt == 8'd0 && ul_cnt == 8'd0);
        return resp;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_responses.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                observed = '{
                    response_kind:    rsp.response_kind,
                    nrc:              rsp.nrc,
                    response_length:  rsp.response_length,
                    counter_echo:     rsp.counter_echo,
                    write_start:      rsp.write_start,
                    read_start:       rsp.read_start,
                    read_address:     rsp.read_address,
                    data_length:      rsp.data_length,
                    enter_exit_state: rsp.enter_exit_state,
                    accepted:         rsp.accepted,
                    fully_idle:       rsp.fully_idle
                };
                if (expected_responses.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    failures++;
                end
                else
                begin
                    wanted = expected_responses.pop_front();
                    check_field("response_kind", 32'(wanted.response_kind),
                                32'(observed.response_kind));
                    check_field("nrc", 32'(wanted.nrc), 32'(observed.nrc));
                    check_field("response_length", 32'(wanted.response_length),
                                32'(observed.response_length));
                    check_field("counter_echo", 32'(wanted.counter_echo),
                                32'(observed.counter_echo));
                    check_field("write_start", 32'(wanted.write_start),
                                32'(observed.write_start));
                    check_field("read_start", 32'(wanted.read_start),
                                32'(observed.read_start));
                    check_field("read_address", wanted.read_address, observed.read_address);
                    check_field("data_length", 32'(wanted.data_length),
                                32'(observed.data_length));
                    check_field("enter_exit_state", 32'(wanted.enter_exit_state),
                                32'(observed.enter_exit_state));
                    check_field("accepted", 32'(wanted.accepted), 32'(observed.accepted));
                    check_field("fully_idle", 32'(wanted.fully_idle),
                                32'(observed.fully_idle));
                end
            end
            if (req.valid && req.ready)
            begin
                incoming = '{
                    func:           req.func,
                    request_length: req.request_length,
                    block_counter:  req.block_counter,
                    direction:      req.direction,
                    address:        req.address,
                    transfer_size:  req.transfer_size,
                    flash_status:   req.flash_status,
                    flash_ready:    req.flash_ready
                };
                expected_responses.push_back(serve_request(incoming));
            end
        end
        outstanding = expected_responses.size();
    end

endmodule

// ===== tb/uds_transfer_data_server_tb.sv =====
// transfer data server testbench top: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module uds_transfer_data_server_tb;
    import uds_td_pkg::*;

    localparam int N_ITEMS = 1400;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_PATTERN
    } rx_mode_t;

    logic     clk;
    logic     rst_n;
    int       failures;
    int       outstanding;
    int       sent_count;
    int       burst_left;
    int       hold_left;
    int       mode_left;
    int       rx_cycle;
    bit [1:0] long_hold_done;
    rx_mode_t rx_mode;

    uds_td_req_if req_ch();
    uds_td_rsp_if rsp_ch();

    uds_transfer_data_server uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    uds_transfer_data_server_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    function automatic req_t make_req(func_t f, logic [12:0] rlen, logic [7:0] bc,
                                      logic [1:0] dir, logic [31:0] addr,
                                      logic [31:0] size, flash_status_t st, logic rdy);
        return '{
            func:           f,
            request_length: rlen,
            block_counter:  bc,
            direction:      dir,
            address:        addr,
            transfer_size:  size,
            flash_status:   st,
            flash_ready:    rdy
        };
    endfunction

    function automatic req_t random_req();
        req_t r;
        r.func           = 2'($urandom_range(0, 3));
        r.request_length = 13'($urandom_range(0, 8191));
        r.block_counter  = 8'($urandom);
        r.direction      = 2'($urandom_range(0, 3));
        r.address        = $urandom;
        r.transfer_size  = $urandom;
        r.flash_status   = 2'($urandom_range(0, 3));
        r.flash_ready    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.func           <= r.func;
        req_ch.request_length <= r.request_length;
        req_ch.block_counter  <= r.block_counter;
        req_ch.direction      <= r.direction;
        req_ch.address        <= r.address;
        req_ch.transfer_size  <= r.transfer_size;
        req_ch.flash_status   <= r.flash_status;
        req_ch.flash_ready    <= r.flash_ready;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_count++;
    endtask

    task automatic download_run();
        req_t        r;
        logic [31:0] size;
        logic [7:0]  blk;
        int          nblk;
        int          max_len;
        r        = random_req();
        r.func   = FN_START;
        r.direction = DIR_DOWNLOAD;
        case ($urandom_range(0, 3))
            0: size = 32'd0;
            1: size = $urandom;
            default: size = $urandom_range(1, 600);
        endcase
        r.transfer_size = size;
        send(r);
        blk  = 8'd1;
        nblk = $urandom_range(1, 6);
        for (int b = 0; b < nblk; b++)
        begin
            if (size > 32'd4094)
            begin
                max_len = ($urandom_range(0, 3) == 0) ? 4094 : 600;
            end
            else
            begin
                max_len = int'(size);
            end
            r                = random_req();
            r.func           = FN_XFER;
            r.block_counter  = blk;
            r.request_length = 13'($urandom_range(0, max_len) + 2);
            r.flash_ready    = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                r.block_counter = 8'($urandom);
            end
            send(r);
            if (!r.flash_ready && r.block_counter == blk)
            begin
                return;
            end
            repeat ($urandom_range(0, 2))
            begin
                r                = random_req();
                r.func           = FN_POLL;
                r.flash_status   = FS_BUSY;
                r.request_length = 13'($urandom_range(2, 300));
                send(r);
            end
            r                = random_req();
            r.func           = FN_POLL;
            r.request_length = 13'($urandom_range(0, max_len) + 2);
            case ($urandom_range(0, 11))
                0: r.flash_status = FS_PROG_FAIL;
                1: r.flash_status = FS_BAD_ADDR;
                default: r.flash_status = FS_SUCCESS;
            endcase
            send(r);
            if (r.flash_status != FS_SUCCESS)
            begin
                return;
            end
            blk = blk + 8'd1;
            if ($urandom_range(0, 3) == 0)
            begin
                r                = random_req();
                r.func           = FN_XFER;
                r.block_counter  = 8'(blk - 8'd1);
                r.request_length = 13'($urandom_range(2, 4097));
                send(r);
            end
            if (size == 32'd0)
            begin
                break;
            end
        end
        if (size == 32'd0 && $urandom_range(0, 1) == 0)
        begin
            r                = random_req();
            r.func           = FN_XFER;
            r.block_counter  = blk;
            r.request_length = 13'd2;
            send(r);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            r      = random_req();
            r.func = FN_EXIT;
            send(r);
        end
    endtask

    task automatic upload_run();
        req_t        r;
        logic [31:0] rem;
        logic [31:0] take;
        logic [7:0]  blk;
        r           = random_req();
        r.func      = FN_START;
        r.direction = DIR_UPLOAD;
        case ($urandom_range(0, 9))
            0: r.transfer_size = 32'd0;
            1, 2: r.transfer_size = $urandom;
            default: r.transfer_size = $urandom_range(1, 12000);
        endcase
        send(r);
        rem = r.transfer_size;
        blk = 8'd1;
        for (int b = 0; b < 8; b++)
        begin
            r                = random_req();
            r.func           = ($urandom_range(0, 1) == 0) ? FN_XFER : FN_POLL;
            r.request_length = 13'($urandom_range(2, 4097));
            r.block_counter  = blk;
            case ($urandom_range(0, 9))
                0: r.block_counter = 8'(blk - 8'd1);
                1: r.block_counter = 8'($urandom);
                default: ;
            endcase
            send(r);
            if (r.block_counter == blk)
            begin
                take = (rem > 32'd4094) ? 32'd4094 : rem;
                rem  = rem - take;
                blk  = blk + 8'd1;
                if (rem == 32'd0)
                begin
                    break;
                end
            end
        end
        if ($urandom_range(0, 1) == 0)
        begin
            r                = random_req();
            r.func           = FN_XFER;
            r.request_length = 13'($urandom_range(2, 100));
            r.block_counter  = 8'(blk - 8'd1);
            send(r);
            r.block_counter  = blk;
            send(r);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            r      = random_req();
            r.func = FN_EXIT;
            send(r);
        end
    endtask

    // receiver: changing stall patterns plus two long hold-offs while requests keep coming
    always @(posedge clk)
    begin
        rx_cycle++;
        if (!long_hold_done[0] && sent_count >= 250)
        begin
            long_hold_done[0] = 1'b1;
            hold_left         = 400;
        end
        if (!long_hold_done[1] && sent_count >= 900)
        begin
            long_hold_done[1] = 1'b1;
            hold_left         = 400;
        end
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:  rsp_ch.ready <= 1'b1;
                RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_HALF:  rsp_ch.ready <= 1'($urandom_range(0, 1));
                default:  rsp_ch.ready <= ((rx_cycle % 7) >= 3);
            endcase
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.func           = FN_START;
        req_ch.request_length = '0;
        req_ch.block_counter  = '0;
        req_ch.direction      = '0;
        req_ch.address        = '0;
        req_ch.transfer_size  = '0;
        req_ch.flash_status   = FS_SUCCESS;
        req_ch.flash_ready    = 1'b0;
        rsp_ch.ready          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle requests, short lengths and invalid directions
        send(make_req(FN_XFER, 13'd10, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd0, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd1, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_START, 13'd0, 8'd0, 2'd2, '1, '1, FS_SUCCESS, 1'b0));
        send(make_req(FN_POLL, 13'h1fff, 8'hff, 2'd0, '0, '0, FS_BUSY, 1'b1));
        send(make_req(FN_START, 13'd0, 8'd0, 2'd3, 32'h1234_5678, 32'd9, FS_SUCCESS, 1'b0));
        // download: writer not ready, oversize block, wrong counter, busy poll
        send(make_req(FN_START, 13'd0, 8'd0, DIR_DOWNLOAD, '0, 32'd0, FS_SUCCESS, 1'b0));
        send(make_req(FN_XFER, 13'd2, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b0));
        send(make_req(FN_START, 13'd0, 8'd0, DIR_DOWNLOAD, 32'h0800_0000, 32'd100,
                      FS_SUCCESS, 1'b0));
        send(make_req(FN_XFER, 13'h1fff, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd10, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd102, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd102, 8'd0, 2'd0, '0, '0, FS_BUSY, 1'b1));
        send(make_req(FN_START, 13'd0, 8'd0, DIR_UPLOAD, '0, 32'd10, FS_SUCCESS, 1'b0));
        send(make_req(FN_POLL, 13'd4098, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd4098, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd4098, 8'd2, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd2, 8'd0, 2'd0, '0, '0, FS_PROG_FAIL, 1'b1));
        // zero-size download reaches the finished phase
        send(make_req(FN_START, 13'd0, 8'd0, DIR_DOWNLOAD, '0, 32'd0, FS_SUCCESS, 1'b0));
        send(make_req(FN_XFER, 13'd2, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd2, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd2, 8'd2, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd2, 8'd0, 2'd0, '0, '0, FS_BAD_ADDR, 1'b1));
        // upload across the address wrap, with repeat and sequence error
        send(make_req(FN_START, 13'd0, 8'd0, DIR_UPLOAD, 32'hffff_f800, 32'd5000,
                      FS_SUCCESS, 1'b0));
        send(make_req(FN_XFER, 13'd5, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd5, 8'd1, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_POLL, 13'd5, 8'd1, 2'd0, '0, '0, FS_BUSY, 1'b1));
        send(make_req(FN_XFER, 13'd5, 8'd2, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_XFER, 13'd5, 8'd3, 2'd0, '0, '0, FS_SUCCESS, 1'b1));
        send(make_req(FN_EXIT, 13'd0, 8'd0, 2'd0, '0, '0, FS_SUCCESS, 1'b0));

        while (sent_count < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: download_run();
                4, 5, 6, 7: upload_run();
                default:
                begin
                    repeat ($urandom_range(1, 4)) send(random_req());
                end
            endcase
        end
        req_ch.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/uds_td_pkg.sv
rtl/uds_td_if.sv
rtl/uds_td_core.sv
rtl/uds_transfer_data_server.sv
tb/uds_transfer_data_server_checker.sv
tb/uds_transfer_data_server_tb.sv
